### hdl/rtfd_pkg.sv
// ----------------------------------------------------------------------------
// rtfd_pkg: shared types and constants for the radar track frame decoder
// Frame identifiers, field codes, CORDIC widths and the arctangent table.
// ----------------------------------------------------------------------------
package rtfd_pkg;

	// frame identifiers
	localparam logic [10:0] SCAN_END_ID = 11'h4E0;
	localparam logic [10:0] TRACK_FIRST = 11'h500;
	localparam logic [10:0] TRACK_LAST  = 11'h53F;

	// measurement status codes that carry a target
	localparam logic [2:0] STATUS_UPDATE  = 3'd3;
	localparam logic [2:0] STATUS_COASTED = 3'd4;

	// result kinds
	localparam logic KIND_TARGET   = 1'b0;
	localparam logic KIND_SCAN_END = 1'b1;

	// range window, 0.1 m units
	localparam logic [10:0] RANGE_MIN = 11'd2;
	localparam logic [10:0] RANGE_MAX = 11'd1000;

	// azimuth wrap, 0.1 degree units
	localparam logic signed [12:0] AZ_FULL     = 13'sd3600;
	localparam logic signed [12:0] AZ_HALF     = 13'sd1800;
	localparam logic signed [12:0] AZ_QUARTER  = 13'sd900;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	// CORDIC datapath
	localparam int CORDIC_STEPS = 16;
	localparam int VEC_W        = 32;
	localparam int ANG_W        = 24;
	// start vector: range_dm * 10 * gain(0.60725 in Q16)
	localparam logic [18:0] C0_SCALE = 19'd397970;
	localparam logic [VEC_W-1:0] ROUND_HALF = VEC_W'(32768);
	localparam logic signed [15:0] POS_LIMIT = 16'sd10000;

	// arctangent of 2^-i, 0.1 degree / 4096 units
	localparam logic signed [ANG_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
		24'sd1843200, 24'sd1088104, 24'sd574925, 24'sd291841,
		24'sd146487,  24'sd73315,   24'sd36666,  24'sd18334,
		24'sd9167,    24'sd4584,    24'sd2292,   24'sd1146,
		24'sd573,     24'sd286,     24'sd143,    24'sd72
	};

	typedef struct packed {
		logic signed [VEC_W-1:0] c;
		logic signed [VEC_W-1:0] s;
		logic signed [ANG_W-1:0] z;
	} cordic_vec_t;

endpackage

### hdl/rtfd_if.sv
// ----------------------------------------------------------------------------
// rtfd channel interfaces
// Frame input channel and decoded result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtfd_in_if;
	logic        valid;
	logic        ready;
	logic [10:0] can_id;
	logic [7:0]  byte_one;
	logic [7:0]  byte_two;
	logic [7:0]  byte_three;
	logic [7:0]  byte_six;
	logic [7:0]  byte_seven;

	modport source (output valid, can_id, byte_one, byte_two, byte_three, byte_six,
		byte_seven, input ready);
	modport sink (input valid, can_id, byte_one, byte_two, byte_three, byte_six,
		byte_seven, output ready);
endinterface

interface rtfd_out_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [5:0]         track_id;
	logic [2:0]         status;
	logic signed [12:0] azimuth;
	logic [9:0]         range_dm;
	logic signed [13:0] speed;
	logic signed [14:0] pos_x;
	logic signed [14:0] pos_y;
	logic [7:0]         target_count;

	modport source (output valid, kind, track_id, status, azimuth, range_dm, speed,
		pos_x, pos_y, target_count, input ready);
	modport sink (input valid, kind, track_id, status, azimuth, range_dm, speed,
		pos_x, pos_y, target_count, output ready);
endinterface

### hdl/rtfd_cell.sv
// ----------------------------------------------------------------------------
// rtfd_cell: one CORDIC rotation cell
// Rotates the vector by +/- atan(2^-STEP) toward zero residual angle.
// ----------------------------------------------------------------------------
module rtfd_cell #(
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  rtfd_pkg::cordic_vec_t in_vec,
	output logic                 out_valid,
	output rtfd_pkg::cordic_vec_t out_vec
);

	logic                          valid_q;
	rtfd_pkg::cordic_vec_t         vec_q;
	rtfd_pkg::cordic_vec_t         vec_next;
	logic signed [rtfd_pkg::VEC_W-1:0] sh_c;
	logic signed [rtfd_pkg::VEC_W-1:0] sh_s;

	assign sh_c = in_vec.c >>> STEP;
	assign sh_s = in_vec.s >>> STEP;

	always_comb begin
		if (!in_vec.z[rtfd_pkg::ANG_W-1]) begin
			vec_next.c = in_vec.c - sh_s;
			vec_next.s = in_vec.s + sh_c;
			vec_next.z = in_vec.z - rtfd_pkg::ATAN_TABLE[STEP];
		end else begin
			vec_next.c = in_vec.c + sh_s;
			vec_next.s = in_vec.s - sh_c;
			vec_next.z = in_vec.z + rtfd_pkg::ATAN_TABLE[STEP];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	// data holds when nothing enters, so the last cell keeps its result
	always_ff @(posedge clk) begin
		if (in_valid) begin
			vec_q <= vec_next;
		end
	end

	assign out_valid = valid_q;
	assign out_vec   = vec_q;

endmodule

### hdl/radar_track_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// radar_track_frame_decoder_top: radar CAN track frame decoder
// Unpacks track frames, adds mounting angle, converts to x/y with a chain of
// CORDIC cells, and emits a target count marker on each scan end frame that
// follows at least one kept target.
//
//  channel   | dir | beat contents
//  ----------+-----+-----------------------------------------------------------
//  in_ch     | in  | can_id, payload bytes 1, 2, 3, 6, 7
//  out_ch    | out | kind, track_id, status, azimuth, range_dm, speed, x, y, count
//  cfg       | in  | cfg_wr_en / cfg_wr_data: mount_angle, 12-bit signed
//
//  A kept track beat passes the launch register, the CORDIC cell chain and
//  the done flag, then loads the output register once out_ch can take it;
//  in_ch.ready returns after that load. arst_n clears control, scan count
//  and mount angle. A stalled output holds the result in the last cell and
//  keeps in_ch.ready low.
//
module radar_track_frame_decoder_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [11:0]        cfg_wr_data,
	rtfd_in_if.sink            in_ch,
	rtfd_out_if.source         out_ch
);

	localparam int STEPS = rtfd_pkg::CORDIC_STEPS;

	// ---------------- configuration ----------------
	logic signed [11:0] mount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_q <= '0;
		end else if (cfg_wr_en) begin
			mount_q <= cfg_wr_data;
		end
	end

	// ---------------- frame decode ----------------
	logic               is_end;
	logic               is_track;
	logic [2:0]         fr_status;
	logic               status_ok;
	logic signed [9:0]  fr_angle;
	logic [10:0]        fr_range;
	logic               range_ok;
	logic signed [13:0] fr_speed;
	logic signed [12:0] az_sum;
	logic signed [12:0] az_wrap;
	logic signed [12:0] az_fold;
	logic               fold_flip;
	logic               keep_track;

	assign is_end    = (in_ch.can_id == rtfd_pkg::SCAN_END_ID);
	assign is_track  = (in_ch.can_id >= rtfd_pkg::TRACK_FIRST) &&
	                   (in_ch.can_id <= rtfd_pkg::TRACK_LAST);
	assign fr_status = in_ch.byte_one[7:5];
	assign status_ok = (fr_status == rtfd_pkg::STATUS_UPDATE) ||
	                   (fr_status == rtfd_pkg::STATUS_COASTED);
	assign fr_angle  = {in_ch.byte_one[4:0], in_ch.byte_two[7:3]};
	assign fr_range  = {in_ch.byte_two[2:0], in_ch.byte_three};
	assign range_ok  = (fr_range >= rtfd_pkg::RANGE_MIN) && (fr_range <= rtfd_pkg::RANGE_MAX);
	assign fr_speed  = {in_ch.byte_six[5:0], in_ch.byte_seven};
	assign keep_track = is_track && status_ok && range_ok;

	// reported azimuth: raw angle plus mount, no wrapping
	assign az_sum = 13'(fr_angle) + 13'(mount_q);

	// wrap to one turn, then fold into +/-90 deg; a fold negates x and y
	always_comb begin
		if (az_sum >= rtfd_pkg::AZ_HALF) begin
			az_wrap = az_sum - rtfd_pkg::AZ_FULL;
		end else if (az_sum < -rtfd_pkg::AZ_HALF) begin
			az_wrap = az_sum + rtfd_pkg::AZ_FULL;
		end else begin
			az_wrap = az_sum;
		end
		fold_flip = 1'b0;
		az_fold   = az_wrap;
		if (az_wrap > rtfd_pkg::AZ_QUARTER) begin
			az_fold   = az_wrap - rtfd_pkg::AZ_HALF;
			fold_flip = 1'b1;
		end else if (az_wrap < -rtfd_pkg::AZ_QUARTER) begin
			az_fold   = az_wrap + rtfd_pkg::AZ_HALF;
			fold_flip = 1'b1;
		end
	end

	// ---------------- control ----------------
	logic       busy_q;
	logic       done_q;
	logic       out_valid_q;
	logic [7:0] count_q;
	logic       in_beat;
	logic       load_marker;
	logic       load_track;
	logic       out_beat;
	logic       chain_out_valid;

	assign in_ch.ready = !busy_q && (!out_valid_q || out_ch.ready);
	assign in_beat     = in_ch.valid && in_ch.ready;
	assign out_beat    = out_valid_q && out_ch.ready;
	assign load_marker = in_beat && is_end && (count_q != '0);
	assign load_track  = done_q && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (in_beat && keep_track) begin
				busy_q <= 1'b1;
			end else if (load_track) begin
				busy_q <= 1'b0;
			end

			if (chain_out_valid) begin
				done_q <= 1'b1;
			end else if (load_track) begin
				done_q <= 1'b0;
			end

			if (load_marker || load_track) begin
				out_valid_q <= 1'b1;
			end else if (out_beat) begin
				out_valid_q <= 1'b0;
			end

			// saturating count of kept targets; cleared by a reported scan end
			if (load_marker) begin
				count_q <= '0;
			end else if (in_beat && keep_track && (count_q != rtfd_pkg::COUNT_MAX)) begin
				count_q <= count_q + 8'd1;
			end
		end
	end

	// ---------------- side fields held for the item in flight ----------------
	logic [5:0]         track_id_q;
	logic [2:0]         status_q;
	logic signed [12:0] azimuth_q;
	logic [9:0]         range_q;
	logic signed [13:0] speed_q;
	logic               flip_q;

	always_ff @(posedge clk) begin
		if (in_beat && keep_track) begin
			track_id_q <= 6'(in_ch.can_id - rtfd_pkg::TRACK_FIRST);
			status_q   <= fr_status;
			azimuth_q  <= az_sum;
			range_q    <= fr_range[9:0];
			speed_q    <= fr_speed;
			flip_q     <= fold_flip;
		end
	end

	// ---------------- launch register ----------------
	logic                  valid_s1;
	rtfd_pkg::cordic_vec_t vec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_beat && keep_track;
		end
	end

	// start vector (r * gain, 0); angle in 0.1 deg / 4096
	always_ff @(posedge clk) begin
		if (in_beat && keep_track) begin
			vec_s1.c <= rtfd_pkg::VEC_W'(fr_range[9:0] * rtfd_pkg::C0_SCALE);
			vec_s1.s <= '0;
			vec_s1.z <= {az_fold[11:0], 12'b0};
		end
	end

	// ---------------- CORDIC cell chain ----------------
	logic                  chain_valid [STEPS+1];
	rtfd_pkg::cordic_vec_t chain_vec   [STEPS+1];

	assign chain_valid[0] = valid_s1;
	assign chain_vec[0]   = vec_s1;

	for (genvar k = 0; k < STEPS; k++) begin : g_cell
		rtfd_cell #(
			.STEP(k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_valid[k]),
			.in_vec   (chain_vec[k]),
			.out_valid(chain_valid[k+1]),
			.out_vec  (chain_vec[k+1])
		);
	end

	assign chain_out_valid = chain_valid[STEPS];

	// ---------------- finish: round, unfold, clamp ----------------
	logic [rtfd_pkg::VEC_W-1:0] s_round;
	logic [rtfd_pkg::VEC_W-1:0] c_round;
	logic signed [15:0]         s_q16;
	logic signed [15:0]         c_q16;
	logic signed [15:0]         x_signed;
	logic signed [15:0]         y_signed;
	logic signed [14:0]         x_sat;
	logic signed [14:0]         y_sat;

	assign s_round = chain_vec[STEPS].s + rtfd_pkg::ROUND_HALF;
	assign c_round = chain_vec[STEPS].c + rtfd_pkg::ROUND_HALF;
	assign s_q16   = s_round[31:16];
	assign c_q16   = c_round[31:16];
	assign x_signed = flip_q ? -s_q16 : s_q16;
	assign y_signed = flip_q ? -c_q16 : c_q16;

	always_comb begin
		if (x_signed > rtfd_pkg::POS_LIMIT) begin
			x_sat = 15'(rtfd_pkg::POS_LIMIT);
		end else if (x_signed < -rtfd_pkg::POS_LIMIT) begin
			x_sat = 15'(-rtfd_pkg::POS_LIMIT);
		end else begin
			x_sat = x_signed[14:0];
		end
		if (y_signed > rtfd_pkg::POS_LIMIT) begin
			y_sat = 15'(rtfd_pkg::POS_LIMIT);
		end else if (y_signed < -rtfd_pkg::POS_LIMIT) begin
			y_sat = 15'(-rtfd_pkg::POS_LIMIT);
		end else begin
			y_sat = y_signed[14:0];
		end
	end

	// ---------------- output register ----------------
	logic               kind_q;
	logic [5:0]         out_track_q;
	logic [2:0]         out_status_q;
	logic signed [12:0] out_az_q;
	logic [9:0]         out_range_q;
	logic signed [13:0] out_speed_q;
	logic signed [14:0] out_x_q;
	logic signed [14:0] out_y_q;
	logic [7:0]         out_count_q;

	always_ff @(posedge clk) begin
		if (load_marker) begin
			kind_q       <= rtfd_pkg::KIND_SCAN_END;
			out_track_q  <= '0;
			out_status_q <= '0;
			out_az_q     <= '0;
			out_range_q  <= '0;
			out_speed_q  <= '0;
			out_x_q      <= '0;
			out_y_q      <= '0;
			out_count_q  <= count_q;
		end else if (load_track) begin
			kind_q       <= rtfd_pkg::KIND_TARGET;
			out_track_q  <= track_id_q;
			out_status_q <= status_q;
			out_az_q     <= azimuth_q;
			out_range_q  <= range_q;
			out_speed_q  <= speed_q;
			out_x_q      <= x_sat;
			out_y_q      <= y_sat;
			out_count_q  <= '0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.kind         = kind_q;
	assign out_ch.track_id     = out_track_q;
	assign out_ch.status       = out_status_q;
	assign out_ch.azimuth      = out_az_q;
	assign out_ch.range_dm     = out_range_q;
	assign out_ch.speed        = out_speed_q;
	assign out_ch.pos_x        = out_x_q;
	assign out_ch.pos_y        = out_y_q;
	assign out_ch.target_count = out_count_q;

	// ---------------- assertions ----------------
	// one item at most travels the launch register and the cell chain
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({valid_s1, chain_valid[1], chain_valid[2], chain_valid[3],
			chain_valid[4], chain_valid[5], chain_valid[6], chain_valid[7],
			chain_valid[8], chain_valid[9], chain_valid[10], chain_valid[11],
			chain_valid[12], chain_valid[13], chain_valid[14], chain_valid[15],
			chain_valid[16]}))
		else $error("more than one item in the CORDIC chain");

	// a finished chain result only exists while an item is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q || chain_out_valid) |-> busy_q)
		else $error("chain result without an item in flight");

	// a scan end marker never reports an empty scan
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.kind == rtfd_pkg::KIND_SCAN_END)) |->
			(out_ch.target_count != '0))
		else $error("empty scan end marker");

	// positions are clamped to the +/-100 m window
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.kind == rtfd_pkg::KIND_TARGET)) |->
			((out_ch.pos_x <= 15'sd10000) && (out_ch.pos_x >= -15'sd10000) &&
			 (out_ch.pos_y <= 15'sd10000) && (out_ch.pos_y >= -15'sd10000)))
		else $error("position out of range");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the radar track frame decoder
// Feeds CAN frames through the input channel, predicts every decoded target
// and scan end marker in-line, and checks each result beat field by field
// across several mounting angles, random stalls and one long output stall.
// ----------------------------------------------------------------------------
module tb;

	// azimuth folding, 0.1 degree units
	localparam longint FULL_TURN   = 3600;
	localparam longint HALF_TURN   = 1800;
	localparam longint QUARTER     = 900;
	// CORDIC: angle in 0.1 degree / 4096, gain 0.60725 in Q16
	localparam longint ANGLE_SCALE = 4096;
	localparam longint XY_GAIN     = 39797;
	localparam longint XY_LIMIT    = 10000;
	localparam int     ROTATIONS   = 16;
	localparam longint ARCTAN_Q [ROTATIONS] = '{
		1843200, 1088104, 574925, 291841, 146487, 73315, 36666, 18334,
		9167, 4584, 2292, 1146, 573, 286, 143, 72
	};

	localparam int SETTLE_CYCLES  = 40;    // covers a kept target's trip through the chain
	localparam int HOLD_CYCLES    = 400;   // long output stall, fills the block
	localparam int WATCHDOG_LIMIT = 4000;  // cycles without a single beat
	localparam int REPORT_LIMIT   = 10;
	localparam int RANDOM_BATCH   = 300;
	localparam int SAT_TARGETS    = 270;   // enough to push the tally past 255

	typedef struct packed {
		logic [10:0] can_id;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic [7:0]  b6;
		logic [7:0]  b7;
	} can_frame_t;

	typedef struct {
		logic               kind;
		logic [5:0]         track_id;
		logic [2:0]         status;
		logic signed [12:0] azimuth;
		logic [9:0]         range_dm;
		logic signed [13:0] speed;
		logic signed [14:0] pos_x;
		logic signed [14:0] pos_y;
		logic [7:0]         target_count;
	} track_report_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [11:0] cfg_wr_data;

	rtfd_in_if  in_ch();
	rtfd_out_if out_ch();

	radar_track_frame_decoder_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	// predictor state: own copy of the mount register and the scan tally
	logic signed [11:0] mount_cfg;
	logic [7:0]         scan_tally;

	can_frame_t    frame_q [$];    // frames waiting for the driver
	track_report_t report_q [$];   // predicted results, oldest first
	int            frames_queued;
	int            frames_taken;
	int            fail_count;

	// idling / pressure controls, written by the sequence, read by the drivers
	logic idle_on;
	logic hold_armed;
	logic hold_taken;
	int   hold_left;
	int   stall_left;
	int   gap_left;
	int   quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Fold azimuth into +-90 degrees (flipping the vector when folded), rotate
	// (range, 0) by the CORDIC, round half up and clip to +-100 m.
	function automatic void cordic_xy(input int az_in, input int rng,
			output logic signed [14:0] px, output logic signed [14:0] py);
		longint az, c, s, z, nc, ns;
		bit     flip;
		int     i;
		az = az_in;
		flip = 1'b0;
		if (az >= HALF_TURN) az -= FULL_TURN;
		else if (az < -HALF_TURN) az += FULL_TURN;
		if (az > QUARTER) begin
			az -= HALF_TURN;
			flip = 1'b1;
		end else if (az < -QUARTER) begin
			az += HALF_TURN;
			flip = 1'b1;
		end
		c = longint'(rng) * 10 * XY_GAIN;
		s = 0;
		z = az * ANGLE_SCALE;
		for (i = 0; i < ROTATIONS; i++) begin
			if (z >= 0) begin
				nc = c - (s >>> i);
				ns = s + (c >>> i);
				z -= ARCTAN_Q[i];
			end else begin
				nc = c + (s >>> i);
				ns = s - (c >>> i);
				z += ARCTAN_Q[i];
			end
			c = nc;
			s = ns;
		end
		s = (s + 32768) >>> 16;
		c = (c + 32768) >>> 16;
		if (flip) begin
			s = -s;
			c = -c;
		end
		px = 15'(s > XY_LIMIT ? XY_LIMIT : (s < -XY_LIMIT ? -XY_LIMIT : s));
		py = 15'(c > XY_LIMIT ? XY_LIMIT : (c < -XY_LIMIT ? -XY_LIMIT : c));
	endfunction

	// Returns 1 when the frame yields a result; updates the scan tally.
	function automatic bit decode_frame(input can_frame_t f, output track_report_t r);
		logic [2:0] st;
		int         ang, rng, spd, az;
		logic signed [14:0] px, py;
		r = '{default: '0};
		if (f.can_id == rtfd_pkg::SCAN_END_ID) begin
			if (scan_tally == 0) return 1'b0;     // empty scan: nothing emitted
			r.kind = rtfd_pkg::KIND_SCAN_END;
			r.target_count = scan_tally;
			scan_tally = '0;
			return 1'b1;
		end
		if (f.can_id < rtfd_pkg::TRACK_FIRST || f.can_id > rtfd_pkg::TRACK_LAST) return 1'b0;
		st = f.b1[7:5];
		if (st != rtfd_pkg::STATUS_UPDATE && st != rtfd_pkg::STATUS_COASTED) return 1'b0;
		ang = $signed({f.b1[4:0], f.b2[7:3]});
		rng = {f.b2[2:0], f.b3};
		spd = $signed({f.b6[5:0], f.b7});
		if (rng < rtfd_pkg::RANGE_MIN || rng > rtfd_pkg::RANGE_MAX) return 1'b0;
		az = ang + mount_cfg;
		cordic_xy(az, rng, px, py);
		if (scan_tally != rtfd_pkg::COUNT_MAX) scan_tally = scan_tally + 8'd1;
		r.kind     = rtfd_pkg::KIND_TARGET;
		r.track_id = 6'(f.can_id - rtfd_pkg::TRACK_FIRST);
		r.status   = st;
		r.azimuth  = 13'(az);
		r.range_dm = 10'(rng);
		r.speed    = 14'(spd);
		r.pos_x    = px;
		r.pos_y    = py;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Frame builders
	// ------------------------------------------------------------------------

	function automatic can_frame_t make_track(input logic [10:0] id, input logic [2:0] st,
			input logic [9:0] ang, input logic [10:0] rng, input logic [13:0] spd);
		can_frame_t f;
		f.can_id = id;
		f.b1 = {st, ang[9:5]};
		f.b2 = {ang[4:0], rng[10:8]};
		f.b3 = rng[7:0];
		f.b6 = {2'($urandom), spd[13:8]};   // bits 7..6 unused, keep them moving
		f.b7 = spd[7:0];
		return f;
	endfunction

	function automatic can_frame_t noise_frame();
		can_frame_t f;
		f.can_id = 11'($urandom);
		f.b1 = 8'($urandom);
		f.b2 = 8'($urandom);
		f.b3 = 8'($urandom);
		f.b6 = 8'($urandom);
		f.b7 = 8'($urandom);
		return f;
	endfunction

	// well-formed target with random content, range extremes now and then
	function automatic can_frame_t good_track();
		logic [10:0] rng;
		logic [2:0]  st;
		if ($urandom_range(0, 7) == 0)
			rng = $urandom_range(0, 1) ? rtfd_pkg::RANGE_MIN : rtfd_pkg::RANGE_MAX;
		else rng = 11'($urandom_range(2, 1000));
		st = $urandom_range(0, 1) ? rtfd_pkg::STATUS_UPDATE : rtfd_pkg::STATUS_COASTED;
		return make_track(rtfd_pkg::TRACK_FIRST + 11'($urandom_range(0, 63)), st,
			10'($urandom), rng, 14'($urandom));
	endfunction

	// mostly good targets, some scan ends, some broken track frames, some noise
	function automatic can_frame_t random_frame();
		can_frame_t f;
		int pick;
		pick = $urandom_range(0, 99);
		f = noise_frame();
		if (pick < 72) f = good_track();
		else if (pick < 80) f.can_id = rtfd_pkg::SCAN_END_ID;
		else if (pick < 90) f.can_id = rtfd_pkg::TRACK_FIRST + 11'($urandom_range(0, 63));
		return f;
	endfunction

	// ------------------------------------------------------------------------
	// Sequence helpers
	// ------------------------------------------------------------------------

	task automatic queue_frame(input can_frame_t f);
		frame_q = {frame_q, f};
		frames_queued++;
	endtask

	task automatic run_random(input int n);
		repeat (n) queue_frame(random_frame());
	endtask

	// mount angle only changes while nothing is in flight
	task automatic set_mount(input logic signed [11:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		mount_cfg = v;
	endtask

	// wait for every frame to be taken and every result to arrive, then let a
	// dropped frame still in the block clear out
	task automatic drain();
		do @(negedge clk);
		while (frames_taken != frames_queued || report_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string tag, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("mismatch on %s: expected %0d, got %0d", tag, exp_v, got_v);
		end
	endtask

	// ------------------------------------------------------------------------
	// Frame driver: holds a beat until taken, random gaps between beats
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : drive_frames
		can_frame_t nxt;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (gap_left > 0) begin
				gap_left    <= gap_left - 1;
				in_ch.valid <= 1'b0;
			end else if (frame_q.size() > 0) begin
				nxt = frame_q.pop_front();
				in_ch.valid      <= 1'b1;
				in_ch.can_id     <= nxt.can_id;
				in_ch.byte_one   <= nxt.b1;
				in_ch.byte_two   <= nxt.b2;
				in_ch.byte_three <= nxt.b3;
				in_ch.byte_six   <= nxt.b6;
				in_ch.byte_seven <= nxt.b7;
				if (idle_on && $urandom_range(0, 9) == 0)
					gap_left <= $urandom_range(1, 15);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver: random stall bursts, one long hold-off when armed
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (hold_armed && !hold_taken) begin
			out_ch.ready <= 1'b0;
			hold_left    <= HOLD_CYCLES - 1;
			hold_taken   <= 1'b1;
		end else if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 11) == 0) begin
			out_ch.ready <= 1'b0;
			stall_left   <= $urandom_range(0, 14);   // start a stall burst of random length
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: predict on each taken frame, check each result beat
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch_channels
		can_frame_t    taken;
		track_report_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				taken = {in_ch.can_id, in_ch.byte_one, in_ch.byte_two, in_ch.byte_three,
					in_ch.byte_six, in_ch.byte_seven};
				frames_taken++;
				if (decode_frame(taken, want)) report_q = {report_q, want};
			end
			if (out_ch.valid && out_ch.ready) begin
				if (report_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("unexpected result beat: kind %0d", out_ch.kind);
				end else begin
					want = report_q.pop_front();
					check_field("kind", want.kind, out_ch.kind);
					check_field("track_id", want.track_id, out_ch.track_id);
					check_field("status", want.status, out_ch.status);
					check_field("azimuth", want.azimuth, out_ch.azimuth);
					check_field("range_dm", want.range_dm, out_ch.range_dm);
					check_field("speed", want.speed, out_ch.speed);
					check_field("pos_x", want.pos_x, out_ch.pos_x);
					check_field("pos_y", want.pos_y, out_ch.pos_y);
					check_field("target_count", want.target_count, out_ch.target_count);
				end
			end
		end
	end

	// watchdog: ends the run if no beat moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready))
			quiet_cycles <= quiet_cycles + 1;
		else
			quiet_cycles <= 0;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int m;
		// every input known from time zero
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = '0;
		in_ch.valid      = 1'b0;
		in_ch.can_id     = '0;
		in_ch.byte_one   = '0;
		in_ch.byte_two   = '0;
		in_ch.byte_three = '0;
		in_ch.byte_six   = '0;
		in_ch.byte_seven = '0;
		out_ch.ready     = 1'b0;
		mount_cfg        = '0;
		scan_tally       = '0;
		frames_queued    = 0;
		frames_taken     = 0;
		fail_count       = 0;
		idle_on          = 1'b1;
		hold_armed       = 1'b0;
		hold_taken       = 1'b0;
		hold_left        = 0;
		stall_left       = 0;
		gap_left         = 0;
		quiet_cycles     = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, both statuses, drops, ids around the window
		set_mount(12'sd0);
		queue_frame(make_track(rtfd_pkg::SCAN_END_ID, 3'd0, 10'd0, 11'd0, 14'd0)); // empty
		queue_frame(make_track(rtfd_pkg::TRACK_FIRST, rtfd_pkg::STATUS_UPDATE,
			10'd0, 11'd2, 14'd0));
		queue_frame(make_track(rtfd_pkg::TRACK_LAST, rtfd_pkg::STATUS_COASTED,
			10'd511, 11'd1000, 14'd8191));
		queue_frame(make_track(11'h520, rtfd_pkg::STATUS_UPDATE, 10'h200, 11'd500, 14'h2000));
		queue_frame(make_track(11'h510, rtfd_pkg::STATUS_UPDATE, 10'd100, 11'd1, 14'd5));
		queue_frame(make_track(11'h510, rtfd_pkg::STATUS_UPDATE, 10'd100, 11'd0, 14'd5));
		queue_frame(make_track(11'h510, rtfd_pkg::STATUS_COASTED, 10'd100, 11'd1001, 14'd5));
		queue_frame(make_track(11'h510, rtfd_pkg::STATUS_COASTED, 10'h3FF, 11'd2047,
			14'h3FFF));
		queue_frame(make_track(11'h511, 3'd0, 10'd10, 11'd300, 14'd7));
		queue_frame(make_track(11'h511, 3'd7, 10'd10, 11'd300, 14'd7));
		queue_frame(make_track(11'h511, 3'd2, 10'd10, 11'd300, 14'd7));
		queue_frame(make_track(11'h511, 3'd5, 10'd10, 11'd300, 14'd7));
		queue_frame(make_track(11'h4FF, rtfd_pkg::STATUS_UPDATE, 10'd10, 11'd300, 14'd7));
		queue_frame(make_track(11'h540, rtfd_pkg::STATUS_UPDATE, 10'd10, 11'd300, 14'd7));
		queue_frame(make_track(11'h000, rtfd_pkg::STATUS_UPDATE, 10'd10, 11'd300, 14'd7));
		queue_frame(make_track(11'h7FF, rtfd_pkg::STATUS_UPDATE, 10'd10, 11'd300, 14'd7));
		queue_frame(make_track(rtfd_pkg::SCAN_END_ID, 3'd7, 10'h3FF, 11'h7FF,
			14'h3FFF));                                                     // count 3
		queue_frame(make_track(rtfd_pkg::SCAN_END_ID, 3'd0, 10'd0, 11'd0, 14'd0)); // empty
		queue_frame(make_track(11'h501, rtfd_pkg::STATUS_UPDATE, 10'd450, 11'd700, 14'd1234));
		queue_frame(make_track(11'h502, rtfd_pkg::STATUS_COASTED, 10'h2D4, 11'd999,
			14'h3F00));
		queue_frame(make_track(11'h503, rtfd_pkg::STATUS_UPDATE, 10'd0, 11'd1000, 14'd0));
		queue_frame(make_track(rtfd_pkg::SCAN_END_ID, 3'd0, 10'd0, 11'd0, 14'd0));
		drain();

		// mount at the positive extreme: wraps past 180 and folded quadrants
		set_mount(12'sd1800);
		run_random(RANDOM_BATCH);
		drain();

		// negative extreme, with one long output stall so the input backs up
		set_mount(-12'sd1800);
		hold_armed <= 1'b1;
		run_random(RANDOM_BATCH);
		drain();

		// mount beyond the nominal window; tally saturation at 255
		set_mount(12'sd2047);
		repeat (SAT_TARGETS) queue_frame(good_track());
		queue_frame(make_track(rtfd_pkg::SCAN_END_ID, 3'd0, 10'd0, 11'd0, 14'd0));
		queue_frame(make_track(rtfd_pkg::SCAN_END_ID, 3'd0, 10'd0, 11'd0, 14'd0));
		drain();

		set_mount(12'sh800);
		run_random(RANDOM_BATCH);
		drain();

		m = $urandom_range(0, 3600);
		set_mount(12'(m - 1800));
		run_random(RANDOM_BATCH);
		drain();

		// closing stretch runs flat out on both sides
		set_mount(12'($urandom));
		idle_on <= 1'b0;
		run_random(RANDOM_BATCH);
		drain();

		if (fail_count == 0 && report_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
